>>> rtl/core/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared sizes, command codes and status codes of the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CMD_W      = 3;
  localparam int STATUS_W   = 2;

  localparam int IN_TDATA_W  = ((DATA_WIDTH + CNT_W + 7) / 8) * 8;
  localparam int OUT_BITS    = 3 * DATA_WIDTH + CNT_W + 1 + STATUS_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;
  localparam logic [CMD_W-1:0] CMD_RESIZE     = 3'd5;
  localparam logic [CMD_W-1:0] CMD_PEEK       = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  // ring index of front + offset, offset below twice the depth minus front
  function automatic addr_t ring_at(input addr_t front, input cnt_t offset);
    logic [CNT_W:0] sum;
    begin
      sum = {{(CNT_W + 1 - ADDR_W){1'b0}}, front} + {1'b0, offset};
      if (sum >= (CNT_W + 1)'(DEPTH)) begin
        sum = sum - (CNT_W + 1)'(DEPTH);
      end
      ring_at = sum[ADDR_W-1:0];
    end
  endfunction

endpackage

>>> rtl/core/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed words in a ring RAM with one word result per command.
// ----------------------------------------------------------------------------
// After accept the command executes, then the front and back are read from ram
//   and the result word is loaded; a pop adds an extra ram read, a growing resize
//   first writes its fill words. One command at a time; the next is taken once
//   the result is loaded into the output register
// reset: synchronous rst_n clears count, front index and control; ram is not
//   cleared, entries are read only after being written
module double_ended_queue (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [dq_pkg::CMD_W-1:0]        in_tuser,   // command
  input  logic [dq_pkg::IN_TDATA_W-1:0]   in_tdata,   // value, new_size
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // popped_value, front_value, back_value, count, is_empty, status
  output logic [dq_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  import dq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_POPW = 3'd2;
  localparam logic [2:0] S_FILL = 3'd3;
  localparam logic [2:0] S_RDF  = 3'd4;
  localparam logic [2:0] S_RDB  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]          state_r, state_nxt;
  logic [CMD_W-1:0]    cmd_r;
  data_t               val_r;
  cnt_t                size_r;
  addr_t               front_pos_r, front_pos_nxt;
  cnt_t                count_r, count_nxt;
  cnt_t                fill_r, fill_nxt;
  data_t               popped_r;
  data_t               front_val_r;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic  wr_en, rd_en;
  addr_t wr_addr, rd_addr;
  data_t wr_data, rd_data;
  logic  in_fire, out_free, is_empty;
  data_t front_out, back_out;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign is_empty   = (count_r == '0);
  assign front_out  = is_empty ? '0 : front_val_r;
  assign back_out   = is_empty ? '0 : rd_data;

  dq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    front_pos_nxt = front_pos_r;
    count_nxt     = count_r;
    fill_nxt      = fill_r;
    status_nxt    = status_r;
    wr_en         = 1'b0;
    wr_addr       = ring_at(front_pos_r, count_r);
    wr_data       = val_r;
    rd_en         = 1'b0;
    rd_addr       = front_pos_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt  = S_EXEC;
          status_nxt = ST_OK;
        end
      end
      S_EXEC: begin
        state_nxt = S_RDF;
        unique case (cmd_r)
          CMD_PUSH_BACK: begin
            if (count_r >= CNT_W'(DEPTH)) begin
              status_nxt = ST_FULL;
            end else begin
              wr_en     = 1'b1;
              count_nxt = count_r + 1'b1;
            end
          end
          CMD_PUSH_FRONT: begin
            if (count_r >= CNT_W'(DEPTH)) begin
              status_nxt = ST_FULL;
            end else begin
              wr_en         = 1'b1;
              wr_addr       = ring_at(front_pos_r, CNT_W'(DEPTH - 1));
              front_pos_nxt = wr_addr;
              count_nxt     = count_r + 1'b1;
            end
          end
          CMD_POP_BACK: begin
            if (is_empty) begin
              status_nxt = ST_EMPTY;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = ring_at(front_pos_r, count_r - 1'b1);
              count_nxt = count_r - 1'b1;
              state_nxt = S_POPW;
            end
          end
          CMD_POP_FRONT: begin
            if (is_empty) begin
              status_nxt = ST_EMPTY;
            end else begin
              rd_en         = 1'b1;
              front_pos_nxt = ring_at(front_pos_r, CNT_W'(1));
              count_nxt     = count_r - 1'b1;
              state_nxt     = S_POPW;
            end
          end
          CMD_CLEAR: begin
            count_nxt     = '0;
            front_pos_nxt = '0;
          end
          CMD_RESIZE: begin
            if (size_r > CNT_W'(DEPTH)) begin
              status_nxt = ST_FULL;
            end else if (size_r > count_r) begin
              fill_nxt  = count_r;
              state_nxt = S_FILL;
            end else begin
              count_nxt = size_r;
            end
          end
          default: begin
          end
        endcase
      end
      S_POPW: begin
        state_nxt = S_RDF;
      end
      S_FILL: begin
        // one fill word per cycle at the back
        wr_en    = 1'b1;
        wr_addr  = ring_at(front_pos_r, fill_r);
        fill_nxt = fill_r + 1'b1;
        if (fill_nxt == size_r) begin
          count_nxt = size_r;
          state_nxt = S_RDF;
        end
      end
      S_RDF: begin
        rd_en     = 1'b1;
        rd_addr   = front_pos_r;
        state_nxt = S_RDB;
      end
      S_RDB: begin
        rd_en     = 1'b1;
        rd_addr   = ring_at(front_pos_r, count_r - 1'b1);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_pos_r <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_pos_r <= front_pos_nxt;
      count_r     <= count_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fill_r     <= fill_nxt;
    status_r   <= status_nxt;
    if (in_fire) begin
      cmd_r    <= in_tuser;
      val_r    <= in_tdata[DATA_WIDTH-1:0];
      size_r   <= in_tdata[DATA_WIDTH +: CNT_W];
      popped_r <= '0;
    end
    if (state_r == S_POPW) begin
      popped_r <= rd_data;
    end
    if (state_r == S_RDB) begin
      front_val_r <= rd_data;
    end
    if (state_r == S_DONE && out_free) begin
      out_data_r <= OUT_TDATA_W'({status_r, is_empty, count_r, back_out, front_out,
                                  popped_r});
    end
  end

endmodule

>>> rtl/core/dq_ram.sv
// ----------------------------------------------------------------------------
// dq_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for double_ended_queue: streams commands with random
// idling and backpressure, predicts every result word and compares it field
// by field against the block's output.
// ----------------------------------------------------------------------------
module tb;
  import dq_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE   = 3'd7;  // undefined code, acts as peek
  localparam int               STALL_LIMIT = 2000;
  localparam int               LONG_HOLD   = 160;
  localparam int               RAND_ITEMS  = 630;
  localparam int               QUIET_TAIL  = 100;

  typedef struct packed {
    data_t                popped;
    data_t                front_v;
    data_t                back_v;
    cnt_t                 count;
    logic                 empty;
    logic [STATUS_W-1:0]  status;
  } dq_result_t;

  // predicts the deque and checks each result word against it
  class deque_scoreboard;
    data_t      ring [DEPTH];
    int         head;
    int         fill;
    dq_result_t pending_results [$];
    int         mismatches;
    int         checked;
    int         cmd_hits [8];
    int         full_flags;
    int         empty_flags;
    int         peak_fill;

    function new();
      head = 0;
      fill = 0;
      mismatches = 0;
      checked = 0;
      full_flags = 0;
      empty_flags = 0;
      peak_fill = 0;
      foreach (cmd_hits[i]) cmd_hits[i] = 0;
    endfunction

    function int slot(input int offset);
      return (head + offset) % DEPTH;
    endfunction

    function void note_command(input logic [CMD_W-1:0] cmd, input data_t val,
                               input cnt_t new_size);
      dq_result_t r;
      r = '0;
      r.status = ST_OK;
      cmd_hits[cmd]++;
      case (cmd)
        CMD_PUSH_BACK: begin
          if (fill >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            ring[slot(fill)] = val;
            fill++;
          end
        end
        CMD_PUSH_FRONT: begin
          if (fill >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            head = slot(DEPTH - 1);
            ring[head] = val;
            fill++;
          end
        end
        CMD_POP_BACK: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.popped = ring[slot(fill - 1)];
            fill--;
          end
        end
        CMD_POP_FRONT: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.popped = ring[head];
            head = slot(1);
            fill--;
          end
        end
        CMD_CLEAR: begin
          fill = 0;
          head = 0;
        end
        CMD_RESIZE: begin
          if (new_size > DEPTH) begin
            r.status = ST_FULL;
          end else begin
            for (int i = fill; i < new_size; i++) ring[slot(i)] = val;
            fill = new_size;
          end
        end
        default: begin
        end
      endcase
      if (fill != 0) begin
        r.front_v = ring[head];
        r.back_v  = ring[slot(fill - 1)];
      end
      r.count = cnt_t'(fill);
      r.empty = (fill == 0);
      if (r.status == ST_FULL) full_flags++;
      if (r.status == ST_EMPTY) empty_flags++;
      if (fill > peak_fill) peak_fill = fill;
      pending_results = {pending_results, r};
    endfunction

    function void flag(input string field, input logic [DATA_WIDTH-1:0] exp_v,
                       input logic [DATA_WIDTH-1:0] act_v);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on word %0d, %s: expected %h, got %h", checked, field,
                 exp_v, act_v);
    endfunction

    function void check_result(input logic [OUT_TDATA_W-1:0] word);
      dq_result_t got;
      dq_result_t want;
      got = word[OUT_BITS-1:0];
      // packed struct lists fields from the top, tdata from the bottom
      got.popped  = word[0 +: DATA_WIDTH];
      got.front_v = word[DATA_WIDTH +: DATA_WIDTH];
      got.back_v  = word[2*DATA_WIDTH +: DATA_WIDTH];
      got.count   = word[3*DATA_WIDTH +: CNT_W];
      got.empty   = word[3*DATA_WIDTH + CNT_W];
      got.status  = word[3*DATA_WIDTH + CNT_W + 1 +: STATUS_W];
      if (pending_results.size() == 0) begin
        flag("unexpected word", '0, '1);
        return;
      end
      want = pending_results[0];
      pending_results.delete(0);
      if (got.popped !== want.popped) flag("popped_value", want.popped, got.popped);
      if (got.front_v !== want.front_v) flag("front_value", want.front_v, got.front_v);
      if (got.back_v !== want.back_v) flag("back_value", want.back_v, got.back_v);
      if (got.count !== want.count) flag("count", want.count, got.count);
      if (got.empty !== want.empty) flag("is_empty", want.empty, got.empty);
      if (got.status !== want.status) flag("status", want.status, got.status);
      checked++;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [CMD_W-1:0]       in_tuser = '0;   // command
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // value, new_size
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // popped_value, front_value, back_value, count, is_empty, status
  logic [OUT_TDATA_W-1:0] out_tdata;

  deque_scoreboard sb = new();
  bit tx_idle_en = 1'b0;
  bit rx_idle_en = 1'b0;
  bit hold_off_req = 1'b0;
  int quiet_cycles = 0;

  double_ended_queue uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // monitor both channels and the no-progress watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_command(in_tuser, in_tdata[0 +: DATA_WIDTH],
                                                  in_tdata[DATA_WIDTH +: CNT_W]);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_word(input logic [CMD_W-1:0] cmd, input data_t val,
                           input cnt_t new_size);
    logic [IN_TDATA_W-1:0] word;
    word = '0;
    word[0 +: DATA_WIDTH] = val;
    word[DATA_WIDTH +: CNT_W] = new_size;
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic data_t pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // mostly near the current fill so the block stays quick, rarely anything
  function automatic cnt_t pick_size();
    int target;
    if ($urandom_range(0, 19) == 0) return cnt_t'($urandom_range(0, 127));
    target = sb.fill + $urandom_range(0, 8) - 4;
    if (target < 0) target = 0;
    if (target > DEPTH) target = DEPTH;
    return cnt_t'(target);
  endfunction

  // mode 0 leans to pushes, 1 to pops, 2 is balanced
  function automatic logic [CMD_W-1:0] pick_command(input int mode);
    int p_push;
    int p_pop;
    int r;
    p_push = (mode == 0) ? 70 : (mode == 1) ? 15 : 43;
    p_pop  = (mode == 0) ? 15 : (mode == 1) ? 70 : 43;
    r = $urandom_range(0, 99);
    if (r < p_push) return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
    if (r < p_push + p_pop) return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
    if (r < p_push + p_pop + 8) return CMD_RESIZE;
    if (r < p_push + p_pop + 12) return $urandom_range(0, 3) ? CMD_PEEK : CMD_SPARE;
    return CMD_CLEAR;
  endfunction

  initial begin
    int mode;
    int seg_left;
    int hold_at;
    int drain_at;
    logic [CMD_W-1:0] cmd;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty corners, extremes, full queue, resize edges, spare code
    send_word(CMD_PEEK, 32'h1234_5678, 7'd0);
    send_word(CMD_POP_BACK, '0, 7'd0);
    send_word(CMD_POP_FRONT, '0, 7'd0);
    send_word(CMD_PUSH_BACK, 32'h7fff_ffff, 7'd0);
    send_word(CMD_PUSH_FRONT, 32'h8000_0000, 7'd0);
    send_word(CMD_PUSH_BACK, 32'hffff_ffff, 7'd0);
    send_word(CMD_PUSH_FRONT, 32'h0000_0000, 7'd0);
    send_word(CMD_SPARE, 32'hdead_beef, 7'd127);
    send_word(CMD_POP_FRONT, '0, 7'd0);
    send_word(CMD_POP_BACK, '0, 7'd0);
    send_word(CMD_RESIZE, 32'h5555_5555, 7'd64);
    send_word(CMD_PUSH_BACK, 32'h0bad_f00d, 7'd0);
    send_word(CMD_PUSH_FRONT, 32'h0bad_f00d, 7'd0);
    send_word(CMD_RESIZE, 32'haaaa_aaaa, 7'd65);
    send_word(CMD_RESIZE, 32'haaaa_aaaa, 7'd127);
    send_word(CMD_RESIZE, 32'haaaa_aaaa, 7'd64);
    send_word(CMD_RESIZE, 32'haaaa_aaaa, 7'd3);
    send_word(CMD_RESIZE, 32'h1111_1111, 7'd3);
    send_word(CMD_POP_FRONT, '0, 7'd0);
    send_word(CMD_CLEAR, '0, 7'd0);
    send_word(CMD_POP_BACK, '0, 7'd0);
    send_word(CMD_RESIZE, 32'haaaa_aaaa, 7'd0);
    send_word(CMD_RESIZE, 32'haaaa_aaaa, 7'd1);
    send_word(CMD_PUSH_FRONT, 32'h8000_0001, 7'd0);
    send_word(CMD_POP_BACK, '0, 7'd0);
    wait_drained();

    // random: each segment picks filling, draining or mixed traffic at random
    hold_at  = $urandom_range(150, 250);
    drain_at = $urandom_range(350, 450);
    seg_left = 0;
    mode = 0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(40, 70);
        mode = $urandom_range(0, 2);
        tx_idle_en = (n < RAND_ITEMS - QUIET_TAIL) && $urandom_range(0, 3) != 0;
        rx_idle_en = (n < RAND_ITEMS - QUIET_TAIL) && $urandom_range(0, 3) != 0;
      end
      seg_left--;
      if (n == RAND_ITEMS - QUIET_TAIL) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      if (n == hold_at) hold_off_req = 1'b1;
      if (n == drain_at) wait_drained();
      cmd = pick_command(mode);
      send_word(cmd, pick_value(), (cmd == CMD_RESIZE) ? pick_size() : cnt_t'($urandom));
    end
    wait_drained();
    repeat (10) @(posedge clk);

    $display("checked %0d result words; pushes %0d/%0d, pops %0d/%0d, clears %0d",
             sb.checked, sb.cmd_hits[CMD_PUSH_BACK], sb.cmd_hits[CMD_PUSH_FRONT],
             sb.cmd_hits[CMD_POP_BACK], sb.cmd_hits[CMD_POP_FRONT], sb.cmd_hits[CMD_CLEAR]);
    $display("resizes %0d, peeks %0d, spare code %0d, full flags %0d, empty flags %0d, peak %0d",
             sb.cmd_hits[CMD_RESIZE], sb.cmd_hits[CMD_PEEK], sb.cmd_hits[CMD_SPARE],
             sb.full_flags, sb.empty_flags, sb.peak_fill);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
